@@ rtl/core/pcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcpc_pkg: shared definitions for the PLL clock and power controller
// Register indexes, reset values, field widths and sequencer types.
// ----------------------------------------------------------------------------
package pcpc_pkg;

  localparam int DATA_W   = 32;
  localparam int IDX_W    = 4;
  localparam int FREQ_W   = 31;
  localparam int RATIO_W  = 3;
  localparam int MULT_W   = 9;
  localparam int DIVS_W   = 7;
  localparam int SHIFT_W  = 2;

  localparam int EXT_CLOCK_HZ_DEF = 12000000;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [IDX_W-1:0] REG_LOCK  = 4'd0;
  localparam logic [IDX_W-1:0] REG_MAIN  = 4'd1;
  localparam logic [IDX_W-1:0] REG_USB   = 4'd2;
  localparam logic [IDX_W-1:0] REG_CCTRL = 4'd3;
  localparam logic [IDX_W-1:0] REG_SLOW  = 4'd4;
  localparam logic [IDX_W-1:0] REG_DIV   = 4'd5;

  localparam logic [DATA_W-1:0] LOCK_RST  = 32'h00ff_ffff;
  localparam logic [DATA_W-1:0] MAIN_RST  = 32'h0005_c080;
  localparam logic [DATA_W-1:0] USB_RST   = 32'h0002_8080;
  localparam logic [DATA_W-1:0] CCTRL_RST = 32'h0007_fff0;
  localparam logic [DATA_W-1:0] SLOW_RST  = 32'h0000_0004;
  localparam logic [DATA_W-1:0] DIV_RST   = 32'h0000_0000;

  localparam logic [DATA_W-1:0] POWER_OFF_VALUE = 32'h0007_fff0;
  localparam int POWER_OFF_BIT = 3;
  localparam int IDLE_BIT      = 2;
  localparam int SLOW_MODE_BIT = 4;

  localparam logic [RATIO_W-1:0] RATIO_1 = 3'd1;
  localparam logic [RATIO_W-1:0] RATIO_2 = 3'd2;
  localparam logic [RATIO_W-1:0] RATIO_4 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    TGT_MAIN,
    TGT_USB,
    TGT_SLOW
  } tgt_t;

endpackage

@@ rtl/core/pcpc_if.sv @@
// ----------------------------------------------------------------------------
// pcpc_if: request and result channels of the clock and power controller
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pcpc_in_if
  import pcpc_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [IDX_W-1:0]  reg_index;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, kind, reg_index, write_data, input ready);
  modport sink   (input valid, kind, reg_index, write_data, output ready);
endinterface

interface pcpc_out_if
  import pcpc_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic               power_off_event;
  logic               idle_event;
  logic [FREQ_W-1:0]  main_pll_hz;
  logic [FREQ_W-1:0]  usb_pll_hz;
  logic [FREQ_W-1:0]  core_clock_hz;
  logic [FREQ_W-1:0]  bus_clock_hz;
  logic [FREQ_W-1:0]  periph_clock_hz;
  logic [RATIO_W-1:0] periph_ratio_out;

  modport source (output valid, read_data, power_off_event, idle_event, main_pll_hz,
                  usb_pll_hz, core_clock_hz, bus_clock_hz, periph_clock_hz,
                  periph_ratio_out, input ready);
  modport sink   (input valid, read_data, power_off_event, idle_event, main_pll_hz,
                  usb_pll_hz, core_clock_hz, bus_clock_hz, periph_clock_hz,
                  periph_ratio_out, output ready);
endinterface

@@ rtl/core/pll_clock_power_controller_top.sv @@
// ----------------------------------------------------------------------------
// pll_clock_power_controller_top: PLL clock and power register block
// Six bus registers with derived PLL, core, bus and peripheral clock rates.
// ----------------------------------------------------------------------------
// A read, or a write that needs no division, goes from the accepted beat
// straight to the result state. A write to a PLL register, or to the slow
// clock register with a nonzero divide, passes the multiply, divide and write-back
// states, the divide running over the NUM_W bits of the PLL numerator: one shared
// restoring divider produces one quotient bit per cycle after a single multiply.
// The block takes a new beat as soon as the result is in the output register.
module pll_clock_power_controller_top
  import pcpc_pkg::*;
#(
  parameter int EXT_CLOCK_HZ = EXT_CLOCK_HZ_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pcpc_in_if.sink     in_ch,
  pcpc_out_if.source  out_ch
);

  localparam int EXT_W = $clog2(EXT_CLOCK_HZ + 1);
  localparam int NUM_W = EXT_W + MULT_W;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [EXT_W-1:0]  EXT_V = EXT_W'(EXT_CLOCK_HZ);
  localparam logic [FREQ_W-1:0] EXT_F = FREQ_W'(EXT_CLOCK_HZ);

  localparam longint unsigned MAIN_NUM =
    longint'(EXT_CLOCK_HZ) * (((MAIN_RST >> 12) & 255) + 8);
  localparam longint unsigned MAIN_DEN = (((MAIN_RST >> 4) & 63) + 2) << (MAIN_RST & 3);
  localparam longint unsigned USB_NUM =
    longint'(EXT_CLOCK_HZ) * (((USB_RST >> 12) & 255) + 8);
  localparam longint unsigned USB_DEN = (((USB_RST >> 4) & 63) + 2) << (USB_RST & 3);
  localparam logic [FREQ_W-1:0] MAIN_HZ_RST = FREQ_W'(MAIN_NUM / MAIN_DEN);
  localparam logic [FREQ_W-1:0] USB_HZ_RST  = FREQ_W'(USB_NUM / USB_DEN);

  state_t state_r, state_nxt;

  logic [DATA_W-1:0]  lock_r, lock_nxt;
  logic [DATA_W-1:0]  main_r, main_nxt;
  logic [DATA_W-1:0]  usb_r, usb_nxt;
  logic [DATA_W-1:0]  cctrl_r, cctrl_nxt;
  logic [DATA_W-1:0]  slow_r, slow_nxt;
  logic [DATA_W-1:0]  div_r, div_nxt;

  logic [FREQ_W-1:0]  main_hz_r, main_hz_nxt;
  logic [FREQ_W-1:0]  usb_hz_r, usb_hz_nxt;
  logic [FREQ_W-1:0]  slow_hz_r, slow_hz_nxt;
  logic [FREQ_W-1:0]  core_hz_r, core_hz_nxt;
  logic [FREQ_W-1:0]  bus_hz_r, bus_hz_nxt;
  logic [FREQ_W-1:0]  per_hz_r, per_hz_nxt;
  logic [RATIO_W-1:0] ratio_r, ratio_nxt;

  logic [DATA_W-1:0]  rd_r, rd_nxt;
  logic               poff_r, poff_nxt;
  logic               idle_r, idle_nxt;

  tgt_t               tgt_r, tgt_nxt;
  logic [MULT_W-1:0]  mult_r, mult_nxt;
  logic [DIVS_W-1:0]  dvs_r, dvs_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [NUM_W-1:0]   quot_r, quot_nxt;
  logic [DIVS_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic               ov_r, ov_nxt;
  logic [DATA_W-1:0]  ov_rd_r, ov_rd_nxt;
  logic               ov_poff_r, ov_poff_nxt;
  logic               ov_idle_r, ov_idle_nxt;
  logic [FREQ_W-1:0]  ov_main_r, ov_main_nxt;
  logic [FREQ_W-1:0]  ov_usb_r, ov_usb_nxt;
  logic [FREQ_W-1:0]  ov_core_r, ov_core_nxt;
  logic [FREQ_W-1:0]  ov_bus_r, ov_bus_nxt;
  logic [FREQ_W-1:0]  ov_per_r, ov_per_nxt;
  logic [RATIO_W-1:0] ov_ratio_r, ov_ratio_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic [DIVS_W:0]        rem_sh;
  logic                   rem_ge;
  logic [NUM_W+FREQ_W-1:0] q_ext;
  logic [FREQ_W-1:0]      q_hz;
  logic [FREQ_W-1:0]      core_v;
  logic [FREQ_W-1:0]      bus_v;
  logic [FREQ_W-1:0]      per_v;
  logic [RATIO_W-1:0]     ratio_v;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !ov_r || out_ch.ready;

  assign rem_sh = {rem_r, quot_r[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_r};
  assign q_ext  = {{FREQ_W{1'b0}}, quot_r} >> shift_r;
  assign q_hz   = (|q_ext[NUM_W+FREQ_W-1:FREQ_W]) ? {FREQ_W{1'b1}} : q_ext[FREQ_W-1:0];

  always_comb begin
    if (slow_r[SLOW_MODE_BIT]) begin
      core_v = (slow_r[2:0] == 3'd0) ? EXT_F : slow_hz_r;
    end else begin
      core_v = main_hz_r;
    end
    if (div_r[2]) begin
      bus_v   = core_v >> 2;
      per_v   = core_v >> 2;
      ratio_v = RATIO_4;
    end else begin
      case (div_r[1:0])
        2'd0: begin
          bus_v   = core_v;
          per_v   = core_v;
          ratio_v = RATIO_1;
        end
        2'd1: begin
          bus_v   = core_v;
          per_v   = core_v >> 1;
          ratio_v = RATIO_2;
        end
        2'd2: begin
          bus_v   = core_v >> 1;
          per_v   = core_v >> 1;
          ratio_v = RATIO_2;
        end
        default: begin
          bus_v   = core_v >> 1;
          per_v   = core_v >> 2;
          ratio_v = RATIO_4;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    lock_nxt     = lock_r;
    main_nxt     = main_r;
    usb_nxt      = usb_r;
    cctrl_nxt    = cctrl_r;
    slow_nxt     = slow_r;
    div_nxt      = div_r;
    main_hz_nxt  = main_hz_r;
    usb_hz_nxt   = usb_hz_r;
    slow_hz_nxt  = slow_hz_r;
    core_hz_nxt  = core_hz_r;
    bus_hz_nxt   = bus_hz_r;
    per_hz_nxt   = per_hz_r;
    ratio_nxt    = ratio_r;
    rd_nxt       = rd_r;
    poff_nxt     = poff_r;
    idle_nxt     = idle_r;
    tgt_nxt      = tgt_r;
    mult_nxt     = mult_r;
    dvs_nxt      = dvs_r;
    shift_nxt    = shift_r;
    quot_nxt     = quot_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    ov_nxt       = ov_r && !out_ch.ready;
    ov_rd_nxt    = ov_rd_r;
    ov_poff_nxt  = ov_poff_r;
    ov_idle_nxt  = ov_idle_r;
    ov_main_nxt  = ov_main_r;
    ov_usb_nxt   = ov_usb_r;
    ov_core_nxt  = ov_core_r;
    ov_bus_nxt   = ov_bus_r;
    ov_per_nxt   = ov_per_r;
    ov_ratio_nxt = ov_ratio_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rd_nxt    = '0;
          poff_nxt  = 1'b0;
          idle_nxt  = 1'b0;
          state_nxt = ST_DONE;
          if (in_ch.kind == KIND_READ) begin
            case (in_ch.reg_index)
              REG_LOCK:  rd_nxt = lock_r;
              REG_MAIN:  rd_nxt = main_r;
              REG_USB:   rd_nxt = usb_r;
              REG_CCTRL: rd_nxt = cctrl_r;
              REG_SLOW:  rd_nxt = slow_r;
              REG_DIV:   rd_nxt = div_r;
              default:   rd_nxt = '1;
            endcase
          end else begin
            case (in_ch.reg_index)
              REG_LOCK: lock_nxt = in_ch.write_data;
              REG_CCTRL: begin
                if (in_ch.write_data[POWER_OFF_BIT]) begin
                  cctrl_nxt = POWER_OFF_VALUE;
                  poff_nxt  = 1'b1;
                end else begin
                  idle_nxt  = !cctrl_r[IDLE_BIT] && in_ch.write_data[IDLE_BIT];
                  cctrl_nxt = in_ch.write_data;
                end
              end
              REG_MAIN, REG_USB: begin
                if (in_ch.reg_index == REG_MAIN) begin
                  main_nxt = in_ch.write_data;
                  tgt_nxt  = TGT_MAIN;
                end else begin
                  usb_nxt = in_ch.write_data;
                  tgt_nxt = TGT_USB;
                end
                mult_nxt  = MULT_W'(in_ch.write_data[19:12]) + MULT_W'(8);
                dvs_nxt   = DIVS_W'(in_ch.write_data[9:4]) + DIVS_W'(2);
                shift_nxt = in_ch.write_data[1:0];
                state_nxt = ST_MUL;
              end
              REG_SLOW: begin
                slow_nxt = in_ch.write_data;
                if (in_ch.write_data[2:0] != 3'd0) begin
                  tgt_nxt   = TGT_SLOW;
                  mult_nxt  = MULT_W'(1);
                  dvs_nxt   = DIVS_W'({in_ch.write_data[2:0], 1'b0});
                  shift_nxt = '0;
                  state_nxt = ST_MUL;
                end
              end
              REG_DIV: div_nxt = in_ch.write_data;
              default: ;
            endcase
          end
        end
      end
      ST_MUL: begin
        quot_nxt  = NUM_W'(EXT_V) * NUM_W'(mult_r);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        quot_nxt = {quot_r[NUM_W-2:0], rem_ge};
        rem_nxt  = rem_ge ? DIVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIVS_W-1:0];
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        case (tgt_r)
          TGT_MAIN: main_hz_nxt = q_hz;
          TGT_USB:  usb_hz_nxt  = q_hz;
          default:  slow_hz_nxt = q_hz;
        endcase
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          core_hz_nxt  = core_v;
          bus_hz_nxt   = bus_v;
          per_hz_nxt   = per_v;
          ratio_nxt    = ratio_v;
          ov_nxt       = 1'b1;
          ov_rd_nxt    = rd_r;
          ov_poff_nxt  = poff_r;
          ov_idle_nxt  = idle_r;
          ov_main_nxt  = main_hz_r;
          ov_usb_nxt   = usb_hz_r;
          ov_core_nxt  = core_v;
          ov_bus_nxt   = bus_v;
          ov_per_nxt   = per_v;
          ov_ratio_nxt = ratio_v;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ov_r      <= 1'b0;
      lock_r    <= LOCK_RST;
      main_r    <= MAIN_RST;
      usb_r     <= USB_RST;
      cctrl_r   <= CCTRL_RST;
      slow_r    <= SLOW_RST;
      div_r     <= DIV_RST;
      main_hz_r <= MAIN_HZ_RST;
      usb_hz_r  <= USB_HZ_RST;
      core_hz_r <= MAIN_HZ_RST;
      bus_hz_r  <= MAIN_HZ_RST;
      per_hz_r  <= MAIN_HZ_RST;
      ratio_r   <= RATIO_1;
    end else begin
      state_r   <= state_nxt;
      ov_r      <= ov_nxt;
      lock_r    <= lock_nxt;
      main_r    <= main_nxt;
      usb_r     <= usb_nxt;
      cctrl_r   <= cctrl_nxt;
      slow_r    <= slow_nxt;
      div_r     <= div_nxt;
      main_hz_r <= main_hz_nxt;
      usb_hz_r  <= usb_hz_nxt;
      core_hz_r <= core_hz_nxt;
      bus_hz_r  <= bus_hz_nxt;
      per_hz_r  <= per_hz_nxt;
      ratio_r   <= ratio_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slow_hz_r  <= slow_hz_nxt;
    rd_r       <= rd_nxt;
    poff_r     <= poff_nxt;
    idle_r     <= idle_nxt;
    tgt_r      <= tgt_nxt;
    mult_r     <= mult_nxt;
    dvs_r      <= dvs_nxt;
    shift_r    <= shift_nxt;
    quot_r     <= quot_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    ov_rd_r    <= ov_rd_nxt;
    ov_poff_r  <= ov_poff_nxt;
    ov_idle_r  <= ov_idle_nxt;
    ov_main_r  <= ov_main_nxt;
    ov_usb_r   <= ov_usb_nxt;
    ov_core_r  <= ov_core_nxt;
    ov_bus_r   <= ov_bus_nxt;
    ov_per_r   <= ov_per_nxt;
    ov_ratio_r <= ov_ratio_nxt;
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.read_data        = ov_rd_r;
  assign out_ch.power_off_event  = ov_poff_r;
  assign out_ch.idle_event       = ov_idle_r;
  assign out_ch.main_pll_hz      = ov_main_r;
  assign out_ch.usb_pll_hz       = ov_usb_r;
  assign out_ch.core_clock_hz    = ov_core_r;
  assign out_ch.bus_clock_hz     = ov_bus_r;
  assign out_ch.periph_clock_hz  = ov_per_r;
  assign out_ch.periph_ratio_out = ov_ratio_r;

endmodule

@@ rtl/core/pcpc_checker.sv @@
// ----------------------------------------------------------------------------
// pcpc_checker: port-level checks for the clock and power controller
// Watches the request and result channels and the reported clock rates.
// ----------------------------------------------------------------------------
module pcpc_checker
  import pcpc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DATA_W-1:0]  out_read_data,
  input logic               out_power_off_event,
  input logic               out_idle_event,
  input logic [FREQ_W-1:0]  out_bus_clock_hz,
  input logic [FREQ_W-1:0]  out_periph_clock_hz,
  input logic [RATIO_W-1:0] out_periph_ratio_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("Result beat changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Request accepted while the previous one is still in work.");

  a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_power_off_event && out_idle_event))
    else $error("Power-off and idle flagged on the same beat.");

  a_ratio_rates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_periph_ratio_out == RATIO_1 || out_periph_ratio_out == RATIO_2 ||
                   out_periph_ratio_out == RATIO_4) &&
                  out_bus_clock_hz >= out_periph_clock_hz)
    else $error("Peripheral ratio or rates inconsistent.");

endmodule

bind pll_clock_power_controller_top pcpc_checker u_pcpc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_read_data        (out_ch.read_data),
  .out_power_off_event  (out_ch.power_off_event),
  .out_idle_event       (out_ch.idle_event),
  .out_bus_clock_hz     (out_ch.bus_clock_hz),
  .out_periph_clock_hz  (out_ch.periph_clock_hz),
  .out_periph_ratio_out (out_ch.periph_ratio_out)
);

@@ test/pll_clock_power_controller_top_tb.sv @@
// ----------------------------------------------------------------------------
// pll_clock_power_controller_top_tb: self-checking bench for the clock block
// Register reads and writes go in through a randomly gapped driver. A local
// model of the registers and derived clock rates predicts every result beat,
// and a monitor with random back-pressure compares each one field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pll_clock_power_controller_top_tb;
  import pcpc_pkg::*;

  localparam int          EXT_HZ       = EXT_CLOCK_HZ_DEF;
  localparam int          RANDOM_ITEMS = 550;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          SETTLE       = 40;
  localparam logic [31:0] FREQ_MAX     = 32'h7fff_ffff;

  typedef struct {
    logic              kind;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
  } reg_access_t;

  typedef struct {
    logic [DATA_W-1:0]  read_data;
    logic               power_off_event;
    logic               idle_event;
    logic [FREQ_W-1:0]  main_hz;
    logic [FREQ_W-1:0]  usb_hz;
    logic [FREQ_W-1:0]  core_hz;
    logic [FREQ_W-1:0]  bus_hz;
    logic [FREQ_W-1:0]  periph_hz;
    logic [RATIO_W-1:0] ratio;
  } clock_status_t;

  logic clk;
  logic rst_n = 1'b0;

  pcpc_in_if  in_ch ();
  pcpc_out_if out_ch ();

  pll_clock_power_controller_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  reg_access_t   pending_access[$];
  clock_status_t expected_status[$];
  reg_access_t   drive_item;

  logic [DATA_W-1:0]  lock_q, main_q, usb_q, cctrl_q, slow_q, div_q;
  logic [FREQ_W-1:0]  main_hz_q, usb_hz_q, core_hz_q, bus_hz_q, periph_hz_q;
  logic [RATIO_W-1:0] ratio_q;

  int errors       = 0;
  int reads_seen   = 0;
  int writes_seen  = 0;
  int power_offs   = 0;
  int idle_entries = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int in_quiet     = 0;
  int out_quiet    = 0;
  int idle_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [FREQ_W-1:0] pll_hz(logic [DATA_W-1:0] pll);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    num = 64'(EXT_HZ) * (64'(pll[19:12]) + 64'd8);
    den = (64'(pll[9:4]) + 64'd2) << pll[1:0];
    quo = num / den;
    if (quo > 64'(FREQ_MAX)) quo = 64'(FREQ_MAX);
    return quo[FREQ_W-1:0];
  endfunction

  function automatic void recompute_clocks();
    logic [FREQ_W-1:0] core;
    main_hz_q = pll_hz(main_q);
    usb_hz_q  = pll_hz(usb_q);
    if (slow_q[SLOW_MODE_BIT]) begin
      if (slow_q[2:0] == 3'd0) core = FREQ_W'(EXT_HZ);
      else core = FREQ_W'(EXT_HZ / (2 * int'(slow_q[2:0])));
    end else begin
      core = main_hz_q;
    end
    core_hz_q = core;
    if (div_q[2]) begin
      bus_hz_q    = core / 4;
      periph_hz_q = core / 4;
      ratio_q     = RATIO_4;
    end else begin
      case (div_q[1:0])
        2'd0: begin
          bus_hz_q    = core;
          periph_hz_q = core;
          ratio_q     = RATIO_1;
        end
        2'd1: begin
          bus_hz_q    = core;
          periph_hz_q = core / 2;
          ratio_q     = RATIO_2;
        end
        2'd2: begin
          bus_hz_q    = core / 2;
          periph_hz_q = core / 2;
          ratio_q     = RATIO_2;
        end
        default: begin
          bus_hz_q    = core / 2;
          periph_hz_q = core / 4;
          ratio_q     = RATIO_4;
        end
      endcase
    end
  endfunction

  function automatic clock_status_t predict_access(reg_access_t acc);
    clock_status_t res;
    res.read_data       = '0;
    res.power_off_event = 1'b0;
    res.idle_event      = 1'b0;
    if (acc.kind == KIND_READ) begin
      reads_seen++;
      case (acc.reg_index)
        REG_LOCK:  res.read_data = lock_q;
        REG_MAIN:  res.read_data = main_q;
        REG_USB:   res.read_data = usb_q;
        REG_CCTRL: res.read_data = cctrl_q;
        REG_SLOW:  res.read_data = slow_q;
        REG_DIV:   res.read_data = div_q;
        default:   res.read_data = '1;
      endcase
    end else begin
      writes_seen++;
      case (acc.reg_index)
        REG_LOCK: lock_q = acc.write_data;
        REG_CCTRL: begin
          if (acc.write_data[POWER_OFF_BIT]) begin
            cctrl_q = POWER_OFF_VALUE;
            res.power_off_event = 1'b1;
            power_offs++;
          end else begin
            if (!cctrl_q[IDLE_BIT] && acc.write_data[IDLE_BIT]) begin
              res.idle_event = 1'b1;
              idle_entries++;
            end
            cctrl_q = acc.write_data;
          end
        end
        REG_MAIN: begin
          main_q = acc.write_data;
          recompute_clocks();
        end
        REG_USB: begin
          usb_q = acc.write_data;
          recompute_clocks();
        end
        REG_SLOW: begin
          slow_q = acc.write_data;
          recompute_clocks();
        end
        REG_DIV: begin
          div_q = acc.write_data;
          recompute_clocks();
        end
        default: ;
      endcase
    end
    res.main_hz   = main_hz_q;
    res.usb_hz    = usb_hz_q;
    res.core_hz   = core_hz_q;
    res.bus_hz    = bus_hz_q;
    res.periph_hz = periph_hz_q;
    res.ratio     = ratio_q;
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int next_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_access(logic kind, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    reg_access_t acc;
    acc.kind       = kind;
    acc.reg_index  = idx;
    acc.write_data = data;
    pending_access.push_back(acc);
  endtask

  task automatic queue_random_access();
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    kind = ($urandom_range(0, 99) < 55) ? KIND_WRITE : KIND_READ;
    if ($urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, int'(REG_DIV)));
    else idx = IDX_W'($urandom_range(int'(REG_DIV) + 1, (1 << IDX_W) - 1));
    data = $urandom();
    if (kind == KIND_WRITE && idx == REG_CCTRL && $urandom_range(0, 3) != 0)
      data[POWER_OFF_BIT] = 1'b0;
    queue_access(kind, idx, data);
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, exp, act);
      errors++;
    end
  endtask

  task automatic check_status();
    clock_status_t exp;
    if (expected_status.size() == 0) begin
      $display("%0t: result beat with no access outstanding, read_data 0x%08h",
               $time, out_ch.read_data);
      errors++;
    end else begin
      exp = expected_status.pop_front();
      check_field("read_data", exp.read_data, out_ch.read_data);
      check_field("power_off_event", 32'(exp.power_off_event), 32'(out_ch.power_off_event));
      check_field("idle_event", 32'(exp.idle_event), 32'(out_ch.idle_event));
      check_field("main_pll_hz", 32'(exp.main_hz), 32'(out_ch.main_pll_hz));
      check_field("usb_pll_hz", 32'(exp.usb_hz), 32'(out_ch.usb_pll_hz));
      check_field("core_clock_hz", 32'(exp.core_hz), 32'(out_ch.core_clock_hz));
      check_field("bus_clock_hz", 32'(exp.bus_hz), 32'(out_ch.bus_clock_hz));
      check_field("periph_clock_hz", 32'(exp.periph_hz), 32'(out_ch.periph_clock_hz));
      check_field("periph_ratio_out", 32'(exp.ratio), 32'(out_ch.periph_ratio_out));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.kind       <= KIND_READ;
      in_ch.reg_index  <= REG_LOCK;
      in_ch.write_data <= '0;
      gap_left = 0;
      lock_q   = LOCK_RST;
      main_q   = MAIN_RST;
      usb_q    = USB_RST;
      cctrl_q  = CCTRL_RST;
      slow_q   = SLOW_RST;
      div_q    = DIV_RST;
      recompute_clocks();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_status.push_back(predict_access(drive_item));
        gap_left = next_gap(in_quiet);
      end
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_access.size() > 0) begin
        drive_item = pending_access.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= drive_item.kind;
        in_ch.reg_index  <= drive_item.reg_index;
        in_ch.write_data <= drive_item.write_data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_status();
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left = next_gap(out_quiet);
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    queue_access(KIND_READ, REG_LOCK, '0);
    queue_access(KIND_READ, REG_MAIN, '1);
    queue_access(KIND_READ, REG_USB, '0);
    queue_access(KIND_READ, REG_CCTRL, '0);
    queue_access(KIND_READ, REG_SLOW, '0);
    queue_access(KIND_READ, REG_DIV, '0);
    queue_access(KIND_READ, '1, '0);
    queue_access(KIND_WRITE, REG_DIV + 4'd4, '1);
    queue_access(KIND_WRITE, REG_MAIN, '1);
    queue_access(KIND_WRITE, REG_MAIN, '0);
    queue_access(KIND_WRITE, REG_USB, '1);
    queue_access(KIND_WRITE, REG_SLOW, 32'h0000_0010);
    queue_access(KIND_WRITE, REG_SLOW, 32'h0000_0017);
    queue_access(KIND_WRITE, REG_SLOW, '0);
    queue_access(KIND_WRITE, REG_DIV, 32'h0000_0004);
    queue_access(KIND_WRITE, REG_DIV, 32'h0000_0003);
    queue_access(KIND_WRITE, REG_DIV, 32'h0000_0002);
    queue_access(KIND_WRITE, REG_DIV, 32'h0000_0001);
    queue_access(KIND_WRITE, REG_DIV, '0);
    queue_access(KIND_WRITE, REG_CCTRL, 32'h0000_0004);
    queue_access(KIND_WRITE, REG_CCTRL, 32'h0000_0004);
    queue_access(KIND_WRITE, REG_CCTRL, 32'h0000_000c);
    queue_access(KIND_READ, REG_CCTRL, '0);
    queue_access(KIND_WRITE, REG_LOCK, '0);
    queue_access(KIND_READ, REG_LOCK, '0);

    for (int i = 0; i < RANDOM_ITEMS / 2; i++) queue_random_access();

    // Hold the sender back until every outstanding result has drained.
    while (pending_access.size() > 0 || in_ch.valid || expected_status.size() > 0)
      @(negedge clk);

    for (int i = 0; i < RANDOM_ITEMS - RANDOM_ITEMS / 2; i++) queue_random_access();

    while (pending_access.size() > 0 || in_ch.valid || expected_status.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Checked %0d reads and %0d writes, each result field by field.",
             reads_seen, writes_seen);
    $display("Power-off requests: %0d, idle entries: %0d, mismatches: %0d.",
             power_offs, idle_entries, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
